// File: rtl/rstp_pkg.sv
// ----------------------------------------------------------------------------
// rstp_pkg
// Shared types and constants for the RSTP root election and hello timer block.
// ----------------------------------------------------------------------------
package rstp_pkg;

  localparam int NUM_PORTS = 10;
  localparam int PORT_W    = 4;
  localparam int ADDR_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int MAC_W     = 48;
  localparam int PRIO_W    = 8;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;

  localparam logic [7:0]        LLC_SAP      = 8'h42;
  localparam logic [7:0]        LLC_UI       = 8'h03;
  localparam logic [15:0]       STP_PROTO    = 16'h0000;
  localparam logic [7:0]        RSTP_VERSION = 8'd2;
  localparam logic [7:0]        BPDU_RST     = 8'd2;
  localparam logic [PRIO_W-1:0] START_PRIO   = 8'h80;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BPDU  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC     = 2'd0,
    CFG_FIRST_PORT  = 2'd1,
    CFG_LAST_PORT   = 2'd2,
    CFG_HELLO_TICKS = 2'd3
  } cfg_idx_t;

  localparam logic EV_REPORT = 1'b0;
  localparam logic EV_HELLO  = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       dsap;
    logic [7:0]       ssap;
    logic [7:0]       llc_control;
    logic [15:0]      protocol_id;
    logic [7:0]       bpdu_version;
    logic [7:0]       bpdu_kind;
    logic [7:0]       bpdu_root_prio;
    logic [MAC_W-1:0] bpdu_root_mac;
  } req_t;

  typedef struct packed {
    logic              event_kind;
    logic [PORT_W-1:0] port;
    logic [7:0]        root_prio;
    logic [MAC_W-1:0]  root_mac;
    logic              root_changed;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic hdr_ok;
    logic wins;
  } eval_t;

endpackage

// File: rtl/rstp_bpdu_eval.sv
// ----------------------------------------------------------------------------
// rstp_bpdu_eval
// Header check of a received BPDU and root priority vector compare.
// ----------------------------------------------------------------------------
module rstp_bpdu_eval import rstp_pkg::*; (
  input  req_t              req,
  input  logic [PRIO_W-1:0] root_prio,
  input  logic [MAC_W-1:0]  root_mac,
  output eval_t             eval
);

  always_comb begin
    eval.hdr_ok = (req.dsap == LLC_SAP) && (req.ssap == LLC_SAP) &&
                  (req.llc_control == LLC_UI) && (req.protocol_id == STP_PROTO) &&
                  (req.bpdu_version == RSTP_VERSION) && (req.bpdu_kind == BPDU_RST);
    // lower priority wins, ties broken by lower MAC
    eval.wins   = (req.bpdu_root_prio < root_prio) ||
                  ((req.bpdu_root_prio == root_prio) && (req.bpdu_root_mac < root_mac));
  end

endmodule

// File: rtl/rstp_root_election_hello_timer.sv
// ----------------------------------------------------------------------------
// rstp_root_election_hello_timer
// Root bridge election from received BPDUs and per-port hello countdown.
// ----------------------------------------------------------------------------
// BPDU: the report is held, then registered from S_FLUSH; new items wait for S_IDLE.
// Start: one counter RAM write per active port in S_LOAD, then the report is registered
//   from S_FLUSH.
// Tick: one RAM read, then one read-modify-write per active port; the last send request
//   is registered from S_FLUSH. Output stalls hold the block back.
// Reset clears root to priority 0x80 / MAC 0; per-entry valid bits read counters as 0.
// ----------------------------------------------------------------------------
module rstp_root_election_hello_timer import rstp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t            state;
  logic [MAC_W-1:0]  own_mac;
  logic [PORT_W-1:0] first_port;
  logic [PORT_W-1:0] last_port;
  logic [CNT_W-1:0]  hello_ticks;

  logic [PRIO_W-1:0] root_prio;
  logic [MAC_W-1:0]  root_mac;
  logic [PORT_W-1:0] idx;
  logic              pend_valid;
  rsp_t              pend;

  // counter RAM
  logic [CNT_W-1:0]  mem [NUM_PORTS];
  logic              vld [NUM_PORTS];
  logic [CNT_W-1:0]  rd_data;
  logic              rd_vld;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W-1:0]  mem_wdata;

  eval_t             eval;
  logic [PORT_W-1:0] top_port;
  logic              range_ok;
  logic              accept;
  logic              slot_free;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_dec;
  logic              fire;
  logic              check_go;
  logic              at_top;
  logic              rsp_push;
  rsp_t              rsp_data;

  rstp_bpdu_eval u_eval (
    .req       (req),
    .root_prio (root_prio),
    .root_mac  (root_mac),
    .eval      (eval)
  );

  assign top_port  = (last_port > PORT_W'(NUM_PORTS - 1)) ? PORT_W'(NUM_PORTS - 1) : last_port;
  assign range_ok  = (first_port <= top_port);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign at_top    = (idx == top_port);

  // never-written entries read as zero
  assign cnt_cur  = rd_vld ? rd_data : '0;
  assign cnt_dec  = cnt_cur - CNT_W'(1);
  assign fire     = (cnt_dec == '0);
  // a second firing port must first move the held request out
  assign check_go = !(fire && pend_valid && !slot_free);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ADDR_W'(idx);
    mem_raddr = ADDR_W'(idx);
    mem_wdata = hello_ticks;
    rsp_push  = 1'b0;
    rsp_data  = pend;
    unique case (state)
      S_IDLE: begin
      end
      S_LOAD: begin
        mem_we = 1'b1;
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_CHECK: begin
        mem_we    = check_go;
        mem_wdata = fire ? hello_ticks : cnt_dec;
        mem_re    = check_go && !at_top;
        mem_raddr = ADDR_W'(idx + PORT_W'(1));
        rsp_push  = check_go && fire && pend_valid;
        rsp_data.last = 1'b0;
      end
      S_FLUSH: begin
        rsp_push      = pend_valid && slot_free;
        rsp_data.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        vld[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld <= vld[mem_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac     <= '0;
      first_port  <= '0;
      last_port   <= PORT_W'(9);
      hello_ticks <= CNT_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC:     own_mac     <= cfg_data[MAC_W-1:0];
        CFG_FIRST_PORT:  first_port  <= cfg_data[PORT_W-1:0];
        CFG_LAST_PORT:   last_port   <= cfg_data[PORT_W-1:0];
        CFG_HELLO_TICKS: hello_ticks <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (slot_free) begin
      rsp_valid <= rsp_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_push) begin
      rsp <= rsp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_prio  <= START_PRIO;
      root_mac   <= '0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              CMD_START: begin
                root_prio         <= START_PRIO;
                root_mac          <= own_mac;
                pend.event_kind   <= EV_REPORT;
                pend.port         <= '0;
                pend.root_prio    <= START_PRIO;
                pend.root_mac     <= own_mac;
                pend.root_changed <= 1'b0;
                pend.last         <= 1'b1;
                pend_valid        <= 1'b1;
                idx               <= first_port;
                state             <= range_ok ? S_LOAD : S_FLUSH;
              end
              CMD_BPDU: begin
                if (eval.hdr_ok) begin
                  if (eval.wins) begin
                    root_prio <= req.bpdu_root_prio;
                    root_mac  <= req.bpdu_root_mac;
                  end
                  pend.event_kind   <= EV_REPORT;
                  pend.port         <= '0;
                  pend.root_prio    <= eval.wins ? req.bpdu_root_prio : root_prio;
                  pend.root_mac     <= eval.wins ? req.bpdu_root_mac : root_mac;
                  pend.root_changed <= eval.wins;
                  pend.last         <= 1'b1;
                  pend_valid        <= 1'b1;
                  state             <= S_FLUSH;
                end
              end
              CMD_TICK: begin
                if (range_ok) begin
                  idx   <= first_port;
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD: begin
          if (at_top) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx + PORT_W'(1);
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (check_go) begin
            if (fire) begin
              pend.event_kind   <= EV_HELLO;
              pend.port         <= idx;
              pend.root_prio    <= root_prio;
              pend.root_mac     <= root_mac;
              pend.root_changed <= 1'b0;
              pend.last         <= 1'b0;
              pend_valid        <= 1'b1;
            end
            if (at_top) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + PORT_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // nothing may be held back once the block takes a new item
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held item left behind on return to idle");

  // only a BPDU report can flag a root change, and it is always the final item
  a_changed_report: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.root_changed) |-> ((rsp.event_kind == EV_REPORT) && rsp.last))
    else $error("root change flagged on a wrong item");

  // hello requests name an active port
  a_hello_port: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.event_kind == EV_HELLO)) |->
      ((rsp.port >= first_port) && (rsp.port <= top_port)))
    else $error("hello request for an inactive port");

  // a report carries port zero
  a_report_port: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.event_kind == EV_REPORT)) |-> (rsp.port == '0))
    else $error("root report with nonzero port");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RSTP root election and hello timer block.
// Directed BPDU, start and tick items, then random phases under several
// idle and stall mixes, with a long output hold-off to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import rstp_pkg::*;

  localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
  localparam logic [47:0] MAC_ONES      = 48'hFFFF_FFFF_FFFF;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PRINT_CAP     = 100;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  cfg_idx_t          cfg_index = CFG_OWN_MAC;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;

  rstp_root_election_hello_timer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // bridge state as the block should hold it
  logic [MAC_W-1:0]  own_mac_cfg;
  logic [3:0]        first_port_cfg;
  logic [3:0]        last_port_cfg;
  logic [CNT_W-1:0]  hello_ticks_cfg;
  logic [PRIO_W-1:0] root_prio_q;
  logic [MAC_W-1:0]  root_mac_q;
  logic [CNT_W-1:0]  hello_cnt [NUM_PORTS];

  req_t        pending_items [$];
  rsp_t        events_due [$];
  int unsigned send_gap_pct  = 0;
  int unsigned rsp_hold_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  logic        hold_kick     = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic rsp_t make_event(input logic kind, input logic [PORT_W-1:0] p,
                                      input logic changed);
    rsp_t r;
    r.event_kind   = kind;
    r.port         = p;
    r.root_prio    = root_prio_q;
    r.root_mac     = root_mac_q;
    r.root_changed = changed;
    r.last         = 1'b0;
    return r;
  endfunction

  // Election and hello countdown for one accepted item; queues its events.
  task automatic elect_and_time(input req_t it);
    int   top;
    int   p;
    int   k;
    logic won;
    rsp_t r;
    rsp_t batch [$];
    top = (int'(last_port_cfg) > NUM_PORTS - 1) ? NUM_PORTS - 1 : int'(last_port_cfg);
    case (it.command)
      CMD_START: begin
        root_prio_q = START_PRIO;
        root_mac_q  = own_mac_cfg;
        for (p = int'(first_port_cfg); p <= top; p++) hello_cnt[p] = hello_ticks_cfg;
        batch.push_back(make_event(EV_REPORT, '0, 1'b0));
      end
      CMD_BPDU: begin
        if (it.dsap == LLC_SAP && it.ssap == LLC_SAP && it.llc_control == LLC_UI &&
            it.protocol_id == STP_PROTO && it.bpdu_version == RSTP_VERSION &&
            it.bpdu_kind == BPDU_RST) begin
          won = (it.bpdu_root_prio < root_prio_q) ||
                (it.bpdu_root_prio == root_prio_q && it.bpdu_root_mac < root_mac_q);
          if (won) begin
            root_prio_q = it.bpdu_root_prio;
            root_mac_q  = it.bpdu_root_mac;
          end
          batch.push_back(make_event(EV_REPORT, '0, won));
        end
      end
      CMD_TICK: begin
        for (p = int'(first_port_cfg); p <= top; p++) begin
          hello_cnt[p] = hello_cnt[p] - 16'd1;
          if (hello_cnt[p] == '0) begin
            hello_cnt[p] = hello_ticks_cfg;
            batch.push_back(make_event(EV_HELLO, PORT_W'(p), 1'b0));
          end
        end
      end
      default: ;
    endcase
    for (k = 0; k < batch.size(); k++) begin
      r = batch[k];
      r.last = (k == batch.size() - 1);
      events_due.push_back(r);
    end
  endtask

  // sender
  always @(posedge clk) begin
    int p;
    if (rst) begin
      req_valid       <= 1'b0;
      req             <= '0;
      own_mac_cfg     = '0;
      first_port_cfg  = 4'd0;
      last_port_cfg   = 4'd9;
      hello_ticks_cfg = 16'd200;
      root_prio_q     = START_PRIO;
      root_mac_q      = '0;
      for (p = 0; p < NUM_PORTS; p++) hello_cnt[p] = '0;
    end else begin
      if (req_valid && !req_stall) elect_and_time(req);
      if (!req_valid || !req_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req       <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // output hold-off, counted here
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (events_due.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: %h", rsp));
        end else begin
          want = events_due.pop_front();
          check_field("event_kind", rsp.event_kind, want.event_kind);
          check_field("port", rsp.port, want.port);
          check_field("root_prio", rsp.root_prio, want.root_prio);
          check_field("root_mac", rsp.root_mac, want.root_mac);
          check_field("root_changed", rsp.root_changed, want.root_changed);
          check_field("last", rsp.last, want.last);
        end
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_hold_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic req_t cmd_item(input logic [1:0] c);
    logic [127:0] raw;
    req_t         it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = req_t'(raw[$bits(req_t)-1:0]);
    it.command = c;
    return it;
  endfunction

  function automatic req_t good_bpdu(input logic [7:0] prio, input logic [47:0] mac);
    req_t it;
    it = cmd_item(CMD_BPDU);
    it.dsap           = LLC_SAP;
    it.ssap           = LLC_SAP;
    it.llc_control    = LLC_UI;
    it.protocol_id    = STP_PROTO;
    it.bpdu_version   = RSTP_VERSION;
    it.bpdu_kind      = BPDU_RST;
    it.bpdu_root_prio = prio;
    it.bpdu_root_mac  = mac;
    return it;
  endfunction

  function automatic logic [7:0] pick_prio();
    case ($urandom_range(4))
      0: return START_PRIO - 8'd1;
      1: return START_PRIO;
      2: return START_PRIO + 8'd1;
      3: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_mac();
    case ($urandom_range(5))
      0: return '0;
      1: return MAC_ONES;
      2: return own_mac_cfg;
      default: return rand48();
    endcase
  endfunction

  // mostly well-formed traffic, some broken headers and plain noise
  function automatic req_t random_item();
    int   sel;
    req_t it;
    sel = $urandom_range(99);
    if (sel < 12) begin
      it = cmd_item(CMD_START);
    end else if (sel < 45) begin
      it = cmd_item(CMD_TICK);
    end else if (sel < 88) begin
      it = good_bpdu(pick_prio(), pick_mac());
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(5))
          0: it.dsap         = 8'($urandom);
          1: it.ssap         = 8'($urandom);
          2: it.llc_control  = 8'($urandom);
          3: it.protocol_id  = 16'($urandom);
          4: it.bpdu_version = 8'($urandom);
          default: it.bpdu_kind = 8'($urandom);
        endcase
      end
    end else if (sel < 96) begin
      it = cmd_item(2'($urandom));
    end else begin
      it = cmd_item(CMD_UNKNOWN);
    end
    return it;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OWN_MAC:    own_mac_cfg     = val;
      CFG_FIRST_PORT: first_port_cfg  = val[3:0];
      CFG_LAST_PORT:  last_port_cfg   = val[3:0];
      default:        hello_ticks_cfg = val[15:0];
    endcase
  endtask

  task automatic set_bridge(input logic [47:0] mac, input logic [3:0] lo,
                            input logic [3:0] hi, input logic [15:0] ticks);
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_FIRST_PORT, {44'd0, lo});
    write_reg(CFG_LAST_PORT, {44'd0, hi});
    write_reg(CFG_HELLO_TICKS, {32'd0, ticks});
    @(negedge clk);
  endtask

  // sender held back until everything owed has come out, then a settle time
  task automatic wait_quiet();
    @(negedge clk);
    while (pending_items.size() != 0 || req_valid || events_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int unsigned gap_pct, input int unsigned hold_pct,
                            input int n);
    int k;
    send_gap_pct = gap_pct;
    rsp_hold_pct = hold_pct;
    for (k = 0; k < n; k++) pending_items.push_back(random_item());
    wait_quiet();
  endtask

  initial begin
    req_t it;
    int   k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: counters still at zero, root MAC zero
    pending_items.push_back(cmd_item(CMD_TICK));           // wraps, no hello
    pending_items.push_back(good_bpdu(START_PRIO, '0));     // tie, no change
    pending_items.push_back(good_bpdu(START_PRIO, MAC_ONES));
    pending_items.push_back(cmd_item(CMD_START));
    pending_items.push_back(good_bpdu(START_PRIO - 8'd1, MAC_ONES));
    pending_items.push_back(good_bpdu(START_PRIO - 8'd1, MAC_ONES));
    pending_items.push_back(good_bpdu(START_PRIO - 8'd1, 48'd1));
    pending_items.push_back(good_bpdu(8'hFF, '0));
    // each header byte wrong on its own, on a BPDU that would otherwise win
    it = good_bpdu(8'd0, '0); it.dsap = 8'h43;           pending_items.push_back(it);
    it = good_bpdu(8'd0, '0); it.ssap = 8'h00;           pending_items.push_back(it);
    it = good_bpdu(8'd0, '0); it.llc_control = 8'hFF;    pending_items.push_back(it);
    it = good_bpdu(8'd0, '0); it.protocol_id = 16'hFFFF; pending_items.push_back(it);
    it = good_bpdu(8'd0, '0); it.bpdu_version = 8'h00;   pending_items.push_back(it);
    it = good_bpdu(8'd0, '0); it.bpdu_kind = 8'hFF;      pending_items.push_back(it);
    pending_items.push_back(good_bpdu(8'd0, '0));
    it = good_bpdu(8'd0, '0); it.command = CMD_UNKNOWN;  pending_items.push_back(it);
    pending_items.push_back(cmd_item(CMD_TICK));
    wait_quiet();

    // hello every tick on all ports, last port beyond the real last one
    set_bridge(MAC_ONES, 4'd0, 4'd15, 16'd1);
    pending_items.push_back(cmd_item(CMD_START));
    pending_items.push_back(cmd_item(CMD_TICK));
    pending_items.push_back(good_bpdu(START_PRIO, MAC_ONES));
    pending_items.push_back(good_bpdu(START_PRIO, MAC_ONES - 48'd1));
    pending_items.push_back(cmd_item(CMD_TICK));
    wait_quiet();

    set_bridge(rand48(), 4'd0, 4'd9, 16'd3);
    run_random(0, 0, 70);
    set_bridge(rand48(), 4'd2, 4'd15, 16'd1);
    run_random(65, 0, 70);
    set_bridge('0, 4'd0, 4'd0, 16'd2);
    run_random(0, 65, 70);
    set_bridge(MAC_ONES, 4'd4, 4'd7, 16'd4);
    run_random(10, 10, 70);
    // zero reload: a reloaded counter only wraps and does not fire again
    set_bridge(rand48(), 4'd3, 4'd12, 16'd0);
    run_random(10, 10, 20);
    // no port in range
    set_bridge(rand48(), 4'd15, 4'd15, 16'hFFFF);
    run_random(10, 10, 20);

    // back the block up: long output hold while ticks keep coming
    set_bridge(rand48(), 4'd0, 4'd9, 16'd1);
    send_gap_pct = 0;
    rsp_hold_pct = 0;
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    pending_items.push_back(cmd_item(CMD_START));
    for (k = 0; k < 30; k++) pending_items.push_back(cmd_item(CMD_TICK));
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
